>>> rtl/mnet_pkg.sv
package mnet_pkg;

    // Sizes of the tracked state
    localparam int NOTE_COUNT    = 128;
    localparam int CHANNEL_COUNT = 16;
    localparam int NOTE_W        = $clog2(NOTE_COUNT);
    localparam int CHAN_W        = $clog2(CHANNEL_COUNT);
    localparam int OWNER_W       = CHAN_W + 1;
    localparam int BEND_W        = 14;
    localparam int DATA_W        = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int REC_W         = BEND_W + 2 * DATA_W;

    // Action codes
    localparam logic [1:0] ACT_EVENT     = 2'd0;
    localparam logic [1:0] ACT_READ_NOTE = 2'd1;
    localparam logic [1:0] ACT_READ_CHAN = 2'd2;

    // MIDI message kinds
    localparam logic [2:0] KIND_NOTE_OFF  = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON   = 3'd1;
    localparam logic [2:0] KIND_CTRL      = 3'd2;
    localparam logic [2:0] KIND_BEND      = 3'd3;
    localparam logic [2:0] KIND_PRESSURE  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMBRE_CC = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CHAN_W-1:0] MASTER_RST    = 4'd0;
    localparam logic [CHAN_W-1:0] LOWER_RST     = 4'd1;
    localparam logic [CHAN_W-1:0] UPPER_RST     = 4'd14;
    localparam logic [DATA_W-1:0] TIMBRE_CC_RST = 7'd74;

    // Bend center flip (raw 14-bit value minus 8192)
    localparam logic [BEND_W-1:0] BEND_CENTER = 14'h2000;
    localparam logic [OWNER_W-1:0] NO_OWNER   = OWNER_W'(CHANNEL_COUNT);

    // Zone codes
    localparam logic [1:0] ZONE_NONE  = 2'd0;
    localparam logic [1:0] ZONE_LOWER = 2'd1;
    localparam logic [1:0] ZONE_UPPER = 2'd2;

    // Expression record: bend, timbre, pressure
    typedef struct packed {
        logic [BEND_W-1:0] bend;
        logic [DATA_W-1:0] timbre;
        logic [DATA_W-1:0] pressure;
    } rec_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture request, launch note memory read
        logic commit;  // update state, load result register
    } cmd_t;

endpackage

>>> rtl/mnet_ram.sv
module mnet_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mnet_ctrl.sv
module mnet_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output mnet_pkg::cmd_t cmd
);
    import mnet_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: accept, then commit once the result register is free
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.load     = 1'b0;
        cmd.commit   = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // An accepted request always moves on to the execute step
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC && !s_ready))
        else $error("accepted request did not enter execute");

    // A commit never overwrites a result that has not been taken
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("commit over a pending result");

    // A commit presents a result and frees the input side
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("commit did not present a result");

endmodule

>>> rtl/mnet_dp.sv
module mnet_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mnet_pkg::cmd_t                 cmd,
    input  logic                           cfg_we,
    input  logic [mnet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mnet_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic [1:0]                     s_action,
    input  logic [2:0]                     s_msg_kind,
    input  logic [mnet_pkg::CHAN_W-1:0]    s_midi_channel,
    input  logic [mnet_pkg::DATA_W-1:0]    s_first_data,
    input  logic [mnet_pkg::DATA_W-1:0]    s_second_data,
    input  logic [mnet_pkg::NOTE_W-1:0]    s_query_note,
    input  logic [mnet_pkg::CHAN_W-1:0]    s_query_channel,
    output logic signed [mnet_pkg::BEND_W-1:0] m_bend,
    output logic [mnet_pkg::DATA_W-1:0]    m_timbre,
    output logic [mnet_pkg::DATA_W-1:0]    m_pressure,
    output logic [mnet_pkg::OWNER_W-1:0]   m_owning_channel,
    output logic                           m_configured,
    output logic [1:0]                     m_detected_zone
);
    import mnet_pkg::*;

    // Configuration
    logic [CHAN_W-1:0] master_reg, lower_reg, upper_reg;
    logic [DATA_W-1:0] timbre_cc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_reg    <= MASTER_RST;
            lower_reg     <= LOWER_RST;
            upper_reg     <= UPPER_RST;
            timbre_cc_reg <= TIMBRE_CC_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MASTER:    master_reg    <= cfg_wdata[CHAN_W-1:0];
                CFG_LOWER:     lower_reg     <= cfg_wdata[CHAN_W-1:0];
                CFG_UPPER:     upper_reg     <= cfg_wdata[CHAN_W-1:0];
                CFG_TIMBRE_CC: timbre_cc_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Captured request
    logic [1:0]        act_reg;
    logic [2:0]        kind_reg;
    logic [CHAN_W-1:0] ch_reg, qc_reg;
    logic [DATA_W-1:0] d1_reg, d2_reg;
    logic [NOTE_W-1:0] qn_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            kind_reg <= s_msg_kind;
            ch_reg   <= s_midi_channel;
            d1_reg   <= s_first_data;
            d2_reg   <= s_second_data;
            qn_reg   <= s_query_note;
            qc_reg   <= s_query_channel;
        end
    end

    // Channel map, channel records, zone state
    logic              map_vld_reg  [CHANNEL_COUNT];
    logic [NOTE_W-1:0] map_note_reg [CHANNEL_COUNT];
    rec_t              chan_rec_reg [CHANNEL_COUNT];
    logic              configured_reg, configured_next;
    logic [1:0]        zone_reg, zone_next;
    logic [NOTE_COUNT-1:0] note_vld_reg;

    // Note record memory; entries not yet written read as zero
    logic              note_we;
    logic [NOTE_W-1:0] note_raddr, note_waddr;
    rec_t              note_wdata, note_q, note_cur;

    assign note_raddr = (s_action == ACT_READ_NOTE) ? s_query_note
                                                    : map_note_reg[s_midi_channel];

    mnet_ram #(.WIDTH(REC_W), .DEPTH(NOTE_COUNT)) u_note_ram (
        .aclk  (aclk),
        .we    (note_we),
        .waddr (note_waddr),
        .wdata (note_wdata),
        .re    (cmd.load),
        .raddr (note_raddr),
        .rdata (note_q)
    );

    logic is_event;
    logic nr_vld;
    logic [NOTE_W-1:0] nr_addr;
    logic [NOTE_W-1:0] rd_addr;
    logic [BEND_W-1:0] bend_val;
    logic is_master, is_member;
    rec_t chan_new;
    logic map_vld_new;
    logic [NOTE_W-1:0] map_note_new;
    logic upd_nr;
    logic [CHAN_W:0] lo_top;

    assign is_event  = (act_reg == ACT_EVENT);
    assign nr_vld    = map_vld_reg[ch_reg];
    assign nr_addr   = map_note_reg[ch_reg];
    assign rd_addr   = is_event ? nr_addr : qn_reg;
    assign note_cur  = note_vld_reg[rd_addr] ? note_q : '0;
    assign bend_val  = {d2_reg, d1_reg} ^ BEND_CENTER;
    assign is_master = (ch_reg == master_reg);
    assign is_member = !is_master && (ch_reg <= upper_reg);
    assign lo_top    = {1'b0, lower_reg} + (CHAN_W+1)'(6);

    // Event update of the channel record, the mapped note record and the map
    always_comb begin
        chan_new     = chan_rec_reg[ch_reg];
        note_wdata   = note_cur;
        upd_nr       = 1'b0;
        map_vld_new  = nr_vld;
        map_note_new = nr_addr;
        if (is_master) begin
            if (kind_reg == KIND_BEND) begin
                chan_new.bend = bend_val;
            end else if (kind_reg == KIND_CTRL && d1_reg == timbre_cc_reg) begin
                chan_new.timbre = d2_reg;
            end
        end else if (is_member) begin
            case (kind_reg)
                KIND_NOTE_OFF: begin
                    map_vld_new = 1'b0;
                end
                KIND_NOTE_ON: begin
                    if (d2_reg != '0) begin
                        note_wdata   = '0;
                        upd_nr       = 1'b1;
                        map_vld_new  = 1'b1;
                        map_note_new = d1_reg;
                    end else begin
                        map_vld_new = 1'b0;
                    end
                end
                KIND_CTRL: begin
                    if (d1_reg == timbre_cc_reg) begin
                        note_wdata.timbre = d2_reg;
                        chan_new.timbre   = d2_reg;
                        upd_nr            = 1'b1;
                    end
                end
                KIND_BEND: begin
                    note_wdata.bend = bend_val;
                    chan_new.bend   = bend_val;
                    upd_nr          = 1'b1;
                end
                KIND_PRESSURE: begin
                    note_wdata.pressure = d1_reg;
                    chan_new.pressure   = d1_reg;
                    upd_nr              = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign note_we    = cmd.commit && is_event && upd_nr && nr_vld;
    assign note_waddr = nr_addr;

    // Zone detection on the first note event on a channel above the master channel
    always_comb begin
        configured_next = configured_reg;
        zone_next       = zone_reg;
        if (is_event && !configured_reg && ch_reg > master_reg && ch_reg <= upper_reg
            && (kind_reg == KIND_NOTE_OFF || kind_reg == KIND_NOTE_ON)) begin
            if (ch_reg >= lower_reg && {1'b0, ch_reg} <= lo_top) begin
                zone_next = ZONE_LOWER;
            end else if ({1'b0, ch_reg} > lo_top) begin
                zone_next = ZONE_UPPER;
            end
            configured_next = 1'b1;
        end
    end

    // Owner search over the map as it stands after this request
    logic [OWNER_W-1:0] owner;
    always_comb begin
        logic v;
        logic [NOTE_W-1:0] n;
        owner = NO_OWNER;
        for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
            v = map_vld_reg[i];
            n = map_note_reg[i];
            if (is_event && ch_reg == CHAN_W'(i)) begin
                v = map_vld_new;
                n = map_note_new;
            end
            if (v && n == qn_reg) begin
                owner = OWNER_W'(i);
            end
        end
    end

    // State update on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                map_vld_reg[i]  <= 1'b0;
                chan_rec_reg[i] <= '0;
            end
            note_vld_reg   <= '0;
            configured_reg <= 1'b0;
            zone_reg       <= ZONE_NONE;
        end else if (cmd.commit && is_event) begin
            map_vld_reg[ch_reg]  <= map_vld_new;
            chan_rec_reg[ch_reg] <= chan_new;
            configured_reg       <= configured_next;
            zone_reg             <= zone_next;
            if (note_we) begin
                note_vld_reg[nr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && is_event) begin
            map_note_reg[ch_reg] <= map_note_new;
        end
    end

    // Result register
    rec_t res_rec;
    always_comb begin
        case (act_reg)
            ACT_EVENT:     res_rec = chan_new;
            ACT_READ_NOTE: res_rec = note_cur;
            ACT_READ_CHAN: res_rec = chan_rec_reg[qc_reg];
            default:       res_rec = '0;
        endcase
    end

    rec_t               out_rec_reg;
    logic [OWNER_W-1:0] out_owner_reg;
    logic               out_cfg_reg;
    logic [1:0]         out_zone_reg;

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_rec_reg   <= res_rec;
            out_owner_reg <= owner;
            out_cfg_reg   <= configured_next;
            out_zone_reg  <= zone_next;
        end
    end

    assign m_bend           = $signed(out_rec_reg.bend);
    assign m_timbre         = out_rec_reg.timbre;
    assign m_pressure       = out_rec_reg.pressure;
    assign m_owning_channel = out_owner_reg;
    assign m_configured     = out_cfg_reg;
    assign m_detected_zone  = out_zone_reg;

    // Zone is only recorded together with the configured flag
    a_zone_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        (zone_reg != ZONE_NONE) |-> configured_reg)
        else $error("zone recorded while unconfigured");

    // Once configured, the zone never changes
    a_zone_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        configured_reg |=> (configured_reg && $stable(zone_reg)))
        else $error("zone changed after configuration");

    // Note memory is only written while committing an event
    a_note_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        note_we |-> (cmd.commit && act_reg == ACT_EVENT && nr_vld))
        else $error("note memory written outside an event commit");

endmodule

>>> rtl/mpe_note_expression_tracker_top.sv
// MPE note expression tracker.
// Input channel (s_valid/s_ready): one request per transfer. s_action selects a
// MIDI event, a note record read or a channel record read; the event fields and
// the query fields travel on their own ports.
// Result channel (m_valid/m_ready): exactly one result per request, in order:
// bend/timbre/pressure of the record, the lowest channel owning s_query_note
// (16 if none), the configured flag and the detected zone.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 master
// channel, 1 lower zone first, 2 upper zone last, 3 timbre controller);
// write only while no request is in flight.
// The request is captured on accept; the result register loads in the execute
// step once it is free. A new request is not accepted until the last one has
// committed (note record memory read on accept, read-modify-write on commit).
// Reset (aresetn low, synchronous): registers to defaults, all channels
// unmapped, all records zero, no result pending. No clearing pass is needed.
// Receiver stall: the result waits in the output register; one more request is
// accepted and held in the execute step until the output register frees up.
module mpe_note_expression_tracker_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mnet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mnet_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [2:0]                     s_msg_kind,
    input  logic [mnet_pkg::CHAN_W-1:0]    s_midi_channel,
    input  logic [mnet_pkg::DATA_W-1:0]    s_first_data,
    input  logic [mnet_pkg::DATA_W-1:0]    s_second_data,
    input  logic [mnet_pkg::NOTE_W-1:0]    s_query_note,
    input  logic [mnet_pkg::CHAN_W-1:0]    s_query_channel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [mnet_pkg::BEND_W-1:0] m_bend,
    output logic [mnet_pkg::DATA_W-1:0]    m_timbre,
    output logic [mnet_pkg::DATA_W-1:0]    m_pressure,
    output logic [mnet_pkg::OWNER_W-1:0]   m_owning_channel,
    output logic                           m_configured,
    output logic [1:0]                     m_detected_zone
);
    import mnet_pkg::*;

    cmd_t cmd;

    // Sequencer
    mnet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // State, memory and result register
    mnet_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_action         (s_action),
        .s_msg_kind       (s_msg_kind),
        .s_midi_channel   (s_midi_channel),
        .s_first_data     (s_first_data),
        .s_second_data    (s_second_data),
        .s_query_note     (s_query_note),
        .s_query_channel  (s_query_channel),
        .m_bend           (m_bend),
        .m_timbre         (m_timbre),
        .m_pressure       (m_pressure),
        .m_owning_channel (m_owning_channel),
        .m_configured     (m_configured),
        .m_detected_zone  (m_detected_zone)
    );

endmodule
